// ----- rtl/ordered_array_list_engine_top_assert.svh -----
// Assertion macros for the ordered array list engine checker.
// Depends on nothing; included by olae_checker.sv.
`ifndef ORDERED_ARRAY_LIST_ENGINE_TOP_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_TOP_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted.
`define OLAE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define OLAE_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/olae_pkg.sv -----
// Package for the ordered array list engine: sizes, field widths,
// operation and status codes. Depends on nothing.
package olae_pkg;

    localparam int CAPACITY   = 16;
    localparam int WORD_WIDTH = 32;

    localparam int OP_W  = 2;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (POS_W > CNT_W) ? (POS_W + 1) : (CNT_W + 1);

    typedef logic [WORD_WIDTH-1:0] t_word;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SORTED = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_SUCCESS   = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

endpackage

// ----- rtl/olae_req_if.sv -----
// Request channel of the ordered array list engine: valid/ready plus payload.
// Depends on olae_pkg.
interface olae_req_if;
    logic                          valid;
    logic                          ready;
    logic [olae_pkg::OP_W-1:0]     operation;
    logic [olae_pkg::POS_W-1:0]    position;
    logic signed [olae_pkg::VAL_W-1:0] value;

    modport source (output valid, output operation, output position, output value,
                    input ready);
    modport sink   (input valid, input operation, input position, input value,
                    output ready);
endinterface

// ----- rtl/olae_rsp_if.sv -----
// Response channel of the ordered array list engine: valid/ready plus payload.
// Depends on olae_pkg.
interface olae_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [olae_pkg::ST_W-1:0]     status;
    logic [olae_pkg::LEN_W-1:0]    list_length;
    logic signed [olae_pkg::VAL_W-1:0] read_value;

    modport source (output valid, output status, output list_length, output read_value,
                    input ready);
    modport sink   (input valid, input status, input list_length, input read_value,
                    output ready);
endinterface

// ----- rtl/ordered_array_list_engine_top.sv -----
// Ordered array list engine: bounded list of signed words held in one RAM.
// Channels: i_req (operation, position, value) in, o_rsp (status,
// list_length, read_value) out, both valid/ready; a request moves when
// valid and ready are high at a rising edge of i_clk.
// One request is worked on at a time. Entries move one slot at a time
// through the RAM read/write port pair: read a slot, write it one slot over.
// A rejected request goes straight to S_FIN; a read fetches its slot and
// takes the RAM data in S_RDGET; a move alternates S_RD and S_WR until the
// last entry has moved or the new value is written, then goes to S_FIN.
// i_req.ready is high while no request is in work; the next request may be
// taken while the last response still waits in the output register.
// When o_rsp.ready is low, the response register holds and a finished
// request waits for it before the engine goes idle again.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending
// response; RAM contents are not cleared, as only slots below the length
// are ever read.
// Depends on olae_pkg, olae_req_if, olae_rsp_if and olae_ram.
module ordered_array_list_engine_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    olae_req_if.sink  i_req,
    olae_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_RDGET,
        S_FIN
    } t_state;

    t_state                        r_state;
    olae_pkg::t_op                 r_op;
    logic [olae_pkg::CMP_W-1:0]    r_pos;
    olae_pkg::t_word               r_val;
    logic [olae_pkg::CNT_W-1:0]    r_count;
    logic [olae_pkg::CNT_W-1:0]    r_k;
    olae_pkg::t_status             r_status;
    logic [olae_pkg::VAL_W-1:0]    r_rdval;

    logic                          r_out_valid;
    olae_pkg::t_status             r_out_status;
    logic [olae_pkg::LEN_W-1:0]    r_out_len;
    logic [olae_pkg::VAL_W-1:0]    r_out_rdval;

    logic                          w_we;
    logic [olae_pkg::ADDR_W-1:0]   w_waddr;
    olae_pkg::t_word               w_wdata;
    logic [olae_pkg::ADDR_W-1:0]   w_raddr;
    olae_pkg::t_word               w_rdata;

    olae_pkg::t_op                 w_in_op;
    logic [olae_pkg::CMP_W-1:0]    w_in_pos;
    logic [olae_pkg::CMP_W-1:0]    w_cnt_ext;
    logic [olae_pkg::CMP_W-1:0]    w_k_ext;
    logic [olae_pkg::CNT_W-1:0]    w_k_dec;
    logic                          w_greater;
    logic                          w_out_free;

    olae_pkg::t_status             n_status;
    t_state                        n_state;
    logic [olae_pkg::CNT_W-1:0]    n_k;

    assign w_in_op   = olae_pkg::t_op'(i_req.operation);
    assign w_in_pos  = olae_pkg::CMP_W'(i_req.position);
    assign w_cnt_ext = olae_pkg::CMP_W'(r_count);
    assign w_k_ext   = olae_pkg::CMP_W'(r_k);
    assign w_k_dec   = r_k - olae_pkg::CNT_W'(1);
    assign w_greater = $signed(w_rdata) > $signed(r_val);
    assign w_out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);

    olae_ram #(
        .WIDTH (olae_pkg::WORD_WIDTH),
        .DEPTH (olae_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // RAM port control: read slot feeding the move, write the slot it lands in
    always_comb begin
        w_we    = 1'b0;
        w_waddr = olae_pkg::ADDR_W'(r_k);
        w_wdata = r_val;
        w_raddr = '0;
        case (r_state)
            S_IDLE: begin
                w_raddr = olae_pkg::ADDR_W'(w_in_pos - olae_pkg::CMP_W'(1));
            end
            S_RD: begin
                case (r_op)
                    olae_pkg::OP_INSERT: begin
                        if (w_k_ext >= r_pos) begin
                            w_raddr = olae_pkg::ADDR_W'(w_k_dec);
                        end else begin
                            w_we = 1'b1;
                        end
                    end
                    olae_pkg::OP_DELETE: begin
                        w_raddr = olae_pkg::ADDR_W'(r_k);
                    end
                    olae_pkg::OP_SORTED: begin
                        if (r_k != '0) begin
                            w_raddr = olae_pkg::ADDR_W'(w_k_dec);
                        end else begin
                            w_we = 1'b1;
                        end
                    end
                    default: begin
                        w_we = 1'b0;
                    end
                endcase
            end
            S_WR: begin
                w_we = 1'b1;
                case (r_op)
                    olae_pkg::OP_INSERT: begin
                        w_wdata = w_rdata;
                    end
                    olae_pkg::OP_DELETE: begin
                        w_waddr = olae_pkg::ADDR_W'(w_k_dec);
                        w_wdata = w_rdata;
                    end
                    olae_pkg::OP_SORTED: begin
                        w_wdata = w_greater ? w_rdata : r_val;
                    end
                    default: begin
                        w_we = 1'b0;
                    end
                endcase
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Start of a new request: rejected ones go straight to the response
    always_comb begin
        n_status = olae_pkg::ST_SUCCESS;
        n_state  = S_FIN;
        n_k      = r_count;
        case (w_in_op)
            olae_pkg::OP_INSERT: begin
                if (r_count == olae_pkg::CNT_W'(olae_pkg::CAPACITY)) begin
                    n_status = olae_pkg::ST_OVERFLOW;
                end else if (w_in_pos == '0 ||
                             w_in_pos > w_cnt_ext + olae_pkg::CMP_W'(1)) begin
                    n_status = olae_pkg::ST_RANGE;
                end else begin
                    n_state = S_RD;
                end
            end
            olae_pkg::OP_DELETE: begin
                if (r_count == '0) begin
                    n_status = olae_pkg::ST_UNDERFLOW;
                end else if (w_in_pos == '0 || w_in_pos > w_cnt_ext) begin
                    n_status = olae_pkg::ST_RANGE;
                end else begin
                    n_k     = olae_pkg::CNT_W'(w_in_pos);
                    n_state = S_RD;
                end
            end
            olae_pkg::OP_SORTED: begin
                if (r_count == olae_pkg::CNT_W'(olae_pkg::CAPACITY)) begin
                    n_status = olae_pkg::ST_OVERFLOW;
                end else begin
                    n_state = S_RD;
                end
            end
            default: begin
                if (w_in_pos == '0 || w_in_pos > w_cnt_ext) begin
                    n_status = olae_pkg::ST_RANGE;
                end else begin
                    n_state = S_RDGET;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a finishing request reloads the register in the same cycle
            if (r_out_valid && o_rsp.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op     <= w_in_op;
                        r_pos    <= w_in_pos;
                        r_val    <= olae_pkg::t_word'($unsigned(i_req.value));
                        r_status <= n_status;
                        r_rdval  <= '0;
                        r_k      <= n_k;
                        r_state  <= n_state;
                    end
                end
                S_RD: begin
                    case (r_op)
                        olae_pkg::OP_INSERT: begin
                            if (w_k_ext >= r_pos) begin
                                r_state <= S_WR;
                            end else begin
                                r_count <= r_count + olae_pkg::CNT_W'(1);
                                r_state <= S_FIN;
                            end
                        end
                        olae_pkg::OP_DELETE: begin
                            if (r_k < r_count) begin
                                r_state <= S_WR;
                            end else begin
                                r_count <= r_count - olae_pkg::CNT_W'(1);
                                r_state <= S_FIN;
                            end
                        end
                        olae_pkg::OP_SORTED: begin
                            if (r_k != '0) begin
                                r_state <= S_WR;
                            end else begin
                                r_count <= r_count + olae_pkg::CNT_W'(1);
                                r_state <= S_FIN;
                            end
                        end
                        default: begin
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_WR: begin
                    case (r_op)
                        olae_pkg::OP_INSERT: begin
                            r_k     <= w_k_dec;
                            r_state <= S_RD;
                        end
                        olae_pkg::OP_DELETE: begin
                            r_k     <= r_k + olae_pkg::CNT_W'(1);
                            r_state <= S_RD;
                        end
                        olae_pkg::OP_SORTED: begin
                            // stop at the first entry not above the new value
                            if (w_greater) begin
                                r_k     <= w_k_dec;
                                r_state <= S_RD;
                            end else begin
                                r_count <= r_count + olae_pkg::CNT_W'(1);
                                r_state <= S_FIN;
                            end
                        end
                        default: begin
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_RDGET: begin
                    r_rdval <= olae_pkg::VAL_W'(w_rdata);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hold until the response register is free
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_len    <= olae_pkg::LEN_W'(r_count);
                        r_out_rdval  <= r_rdval;
                        r_state      <= S_IDLE;
                    end else begin
                        r_out_valid  <= r_out_valid;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.list_length = r_out_len;
    assign o_rsp.read_value  = $signed(r_out_rdval);

endmodule

// ----- rtl/olae_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module olae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/olae_checker.sv -----
// Port-level checker for the ordered array list engine, bound to the top.
// Depends on olae_pkg and ordered_array_list_engine_top_assert.svh.
`include "ordered_array_list_engine_top_assert.svh"

module olae_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [olae_pkg::ST_W-1:0]     i_status,
    input logic [olae_pkg::LEN_W-1:0]    i_list_length,
    input logic [olae_pkg::VAL_W-1:0]    i_read_value
);

    `OLAE_ASSERT_RST(a_rst_clears_rsp, i_clk, !i_rst_n |=> !i_rsp_valid, "response valid after reset")

    `OLAE_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status) && $stable(i_list_length) && $stable(i_read_value), "stalled response changed")

    `OLAE_ASSERT(a_ovf_full, i_clk, i_rst_n, i_rsp_valid && i_status == olae_pkg::ST_OVERFLOW |-> i_list_length == olae_pkg::LEN_W'(olae_pkg::CAPACITY), "overflow with list not full")

    `OLAE_ASSERT(a_udf_empty, i_clk, i_rst_n, i_rsp_valid && i_status == olae_pkg::ST_UNDERFLOW |-> i_list_length == '0, "underflow with list not empty")

    `OLAE_ASSERT(a_fail_zero, i_clk, i_rst_n, i_rsp_valid && i_status != olae_pkg::ST_SUCCESS |-> i_read_value == '0, "failed request returned data")

endmodule

bind ordered_array_list_engine_top olae_checker u_olae_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_list_length (o_rsp.list_length),
    .i_read_value  (o_rsp.read_value)
);
